// File: rtl/ffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int LEN_W          = 41;
    localparam int CFG_W          = 41;
    localparam int GRAN_W         = 5;
    localparam int ALIGN_W        = 6;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int DEF_MAX_EXTENTS = 64;
    localparam int DEF_OFFSET_BITS = 40;
    localparam logic [GRAN_W-1:0] GRAN_RESET = 5'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_HEAP    = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_HEAP_BYTES = 1'b0,
        CFG_GRANULE    = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // issue read of entry idx
        S_WAIT,    // RAM latency
        S_EVAL,    // examine entry
        S_PRED,    // release: read predecessor
        S_PWAIT,
        S_PEVAL,
        S_DECIDE,  // release: choose merge action
        S_SHR,     // shift entries up for insert
        S_SHRW,
        S_SHL,     // shift entries down for remove
        S_SHLW,
        S_WRITE,   // final entry updates
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/ffa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ffa_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ffa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/first_fit_free_list_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit heap allocator over a sorted, coalesced table of free extents.
// ----------------------------------------------------------------------------
// Requests arrive on req (mode, req_bytes, align_log2, release_offset); one
// response word per request leaves on rsp (status, grant_offset, grant_bytes,
// free_bytes, extent_count). The user must write heap_bytes and granule_log2
// via cfg_we/cfg_index/cfg_data only while idle; the core does not enforce it.
// The extent table sits in one single-port RAM; a sequencer walks it one entry
// at a time (address, read latency, evaluate) with datapath terms shared
// across states. An allocate scans up to the first fitting entry; a release
// scans up to its insertion point. Inserting or removing an entry moves every
// later entry by one, with a read and a write per entry.
// req.ready is high only in idle with no response waiting. The response is
// held in an output register until taken; while rsp is stalled, no new request
// is accepted.
// Reset empties the table (count 0, free total 0), heap_bytes = 0 and
// granule_log2 = 8. Table contents need no clearing.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core
    import ffa_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    ffa_if.sink                   req,
    ffa_if.source                 rsp
);
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int OW = OFFSET_BITS;
    localparam int EW = OW + LEN_W;
    localparam int XW = 65; // wide enough for start + aligned sums

    // config
    logic [LEN_W-1:0]  heap_reg;
    logic [GRAN_W-1:0] gran_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= '0;
            gran_reg <= GRAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEAP_BYTES: heap_reg <= cfg_data[LEN_W-1:0];
                CFG_GRANULE:    gran_reg <= cfg_data[GRAN_W-1:0];
                default:        ;
            endcase
        end
    end

    // RAM
    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    wire logic [OW-1:0]    rd_s = ram_rdata[EW-1:LEN_W];
    wire logic [LEN_W-1:0] rd_l = ram_rdata[LEN_W-1:0];

    // registers
    state_t             state_reg, state_next;
    logic [CW-1:0]      used_reg, used_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [XW-1:0]      size_reg, size_next;     // rounded size or release len
    logic [XW-1:0]      amask_reg, amask_next;   // a-1
    logic [XW-1:0]      off_reg, off_next;       // release offset
    logic [CW-1:0]      idx_reg, idx_next;       // scan pointer / p
    logic [CW-1:0]      mv_reg, mv_next;         // shift pointer
    logic [LEN_W-1:0]   pl_reg, pl_next;         // entry length
    logic [XW-1:0]      as_reg, as_next;
    logic               ms_reg, ms_next;
    logic [LEN_W-1:0]   sl_reg, sl_next;         // successor length
    // pending writes: w0 at idx w0a, optional w1 at w1a
    logic [EW-1:0]      w0_reg, w0_next, w1_reg, w1_next;
    logic [CW-1:0]      w0a_reg, w0a_next, w1a_reg, w1a_next;
    logic               w1v_reg, w1v_next;
    logic               wph_reg, wph_next;
    logic               ovld_reg, ovld_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic [LEN_W-1:0]   ogo_reg, ogo_next, ogb_reg, ogb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            total_reg <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;  size_reg <= size_next;  amask_reg <= amask_next;
        off_reg <= off_next;    idx_reg <= idx_next;    mv_reg <= mv_next;
        pl_reg <= pl_next;      as_reg <= as_next;
        ms_reg <= ms_next;      sl_reg <= sl_next;
        w0_reg <= w0_next;      w1_reg <= w1_next;
        w0a_reg <= w0a_next;    w1a_reg <= w1a_next;    w1v_reg <= w1v_next;
        wph_reg <= wph_next;
        ost_reg <= ost_next;    ogo_reg <= ogo_next;    ogb_reg <= ogb_next;
    end

    // heap limit clamped to 2^OFFSET_BITS
    logic [XW-1:0] cap, limit;
    assign cap   = XW'(1) << OW;
    assign limit = ({{(XW-LEN_W){1'b0}}, heap_reg} > cap) ? cap
                 : {{(XW-LEN_W){1'b0}}, heap_reg};

    // shared datapath terms from the current entry
    logic [XW-1:0] ext_s, ext_e, ext_as, ext_ae, gmask;
    assign ext_s  = {{(XW-OW){1'b0}}, rd_s};
    assign ext_e  = ext_s + {{(XW-LEN_W){1'b0}}, rd_l};
    assign ext_as = (ext_s + amask_reg) & ~amask_reg;
    assign ext_ae = ext_as + size_reg;
    assign gmask  = (XW'(1) << gran_reg) - XW'(1);

    logic [CW-1:0] used_m1;
    assign used_m1 = used_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;   total_next = total_reg;
        mode_next = mode_reg;   size_next = size_reg;   amask_next = amask_reg;
        off_next = off_reg;     idx_next = idx_reg;     mv_next = mv_reg;
        pl_next = pl_reg;       as_next = as_reg;
        ms_next = ms_reg;       sl_next = sl_reg;
        w0_next = w0_reg;       w1_next = w1_reg;
        w0a_next = w0a_reg;     w1a_next = w1a_reg;     w1v_next = w1v_reg;
        wph_next = wph_reg;
        ovld_next = ovld_reg;   ost_next = ost_reg;
        ogo_next = ogo_reg;     ogb_next = ogb_reg;
        if (ovld_reg && rsp.ready)
        begin
            ovld_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && !ovld_reg)
                begin
                    mode_next = req.data.mode;
                    idx_next = '0;
                    w1v_next = 1'b0; wph_next = 1'b0;
                    ost_next = ST_OK; ogo_next = '0; ogb_next = '0;
                    amask_next = (XW'(1) << req.data.align_log2) - XW'(1);
                    off_next = {{(XW-LEN_W){1'b0}}, req.data.release_offset};
                    state_next = S_DONE;
                    case (mode_t'(req.data.mode))
                        MODE_ALLOC:
                        begin
                            size_next = ({{(XW-LEN_W){1'b0}}, req.data.req_bytes} + gmask)
                                        & ~gmask;
                            state_next = S_RD;
                        end
                        MODE_RELEASE:
                        begin
                            size_next = {{(XW-LEN_W){1'b0}}, req.data.req_bytes};
                            if (req.data.req_bytes == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else if ({{(XW-LEN_W){1'b0}}, req.data.release_offset}
                                     + {{(XW-LEN_W){1'b0}}, req.data.req_bytes} > limit)
                            begin
                                ost_next = ST_FAIL;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        MODE_HEAP:
                        begin
                            used_next = '0;
                            total_next = '0;
                            if (limit != '0)
                            begin
                                used_next = CW'(1);
                                total_next = limit[LEN_W-1:0];
                                w0_next = {OW'(0), limit[LEN_W-1:0]};
                                w0a_next = '0;
                                state_next = S_WRITE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    // end of table
                    if (mode_reg == MODE_ALLOC)
                    begin
                        ost_next = ST_FAIL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PRED;
                    end
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: state_next = S_EVAL;
            S_EVAL:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (ext_ae > ext_e)
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        ogo_next = ext_as[LEN_W-1:0];
                        ogb_next = size_reg[LEN_W-1:0];
                        state_next = S_DONE;
                        w0a_next = idx_reg;
                        w1a_next = idx_reg + CW'(1);
                        if (size_reg != '0)
                        begin
                            if (ext_as == ext_s && ext_ae == ext_e)
                            begin
                                mv_next = idx_reg;
                                state_next = S_SHL;
                            end
                            else if (ext_as == ext_s)
                            begin
                                w0_next = {ext_ae[OW-1:0], LEN_W'(ext_e - ext_ae)};
                                state_next = S_WRITE;
                            end
                            else if (ext_ae == ext_e)
                            begin
                                w0_next = {rd_s, LEN_W'(ext_as - ext_s)};
                                state_next = S_WRITE;
                            end
                            else if (used_reg >= CW'(MAX_EXTENTS))
                            begin
                                ost_next = ST_FULL;
                                ogo_next = '0; ogb_next = '0;
                            end
                            else
                            begin
                                w0_next = {rd_s, LEN_W'(ext_as - ext_s)};
                                w1_next = {ext_ae[OW-1:0], LEN_W'(ext_e - ext_ae)};
                                w1v_next = 1'b1;
                                mv_next = used_reg;
                                state_next = S_SHR;
                            end
                            if (!(used_reg >= CW'(MAX_EXTENTS) && ext_as != ext_s
                                  && ext_ae != ext_e))
                            begin
                                total_next = total_reg - size_reg[LEN_W-1:0];
                            end
                        end
                    end
                end
                else
                begin
                    // release: find first start > off
                    if (ext_s <= off_reg)
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        ms_next = (ext_s == off_reg + size_reg);
                        sl_next = rd_l;
                        state_next = S_PRED;
                    end
                end
            end
            S_PRED:
            begin
                if (idx_reg >= used_reg)
                begin
                    ms_next = 1'b0;
                end
                state_next = (idx_reg == '0) ? S_DECIDE : S_PWAIT;
                pl_next = '0;
                if (idx_reg == '0)
                begin
                    as_next = '1; // no predecessor: never touches
                end
            end
            S_PWAIT: state_next = S_PEVAL;
            S_PEVAL:
            begin
                as_next = ext_e;
                pl_next = rd_l;
                w1_next = {rd_s, rd_l};
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_WRITE;
                if (as_reg == off_reg && ms_reg)
                begin
                    w0a_next = idx_reg - CW'(1);
                    w0_next = {w1_reg[EW-1:LEN_W], pl_reg + size_reg[LEN_W-1:0] + sl_reg};
                    mv_next = idx_reg;
                    state_next = S_SHL;
                    total_next = total_reg + size_reg[LEN_W-1:0];
                end
                else if (as_reg == off_reg)
                begin
                    w0a_next = idx_reg - CW'(1);
                    w0_next = {w1_reg[EW-1:LEN_W], pl_reg + size_reg[LEN_W-1:0]};
                    total_next = total_reg + size_reg[LEN_W-1:0];
                end
                else if (ms_reg)
                begin
                    w0a_next = idx_reg;
                    w0_next = {off_reg[OW-1:0], sl_reg + size_reg[LEN_W-1:0]};
                    total_next = total_reg + size_reg[LEN_W-1:0];
                end
                else if (used_reg >= CW'(MAX_EXTENTS))
                begin
                    ost_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    w0a_next = idx_reg;
                    w0_next = {off_reg[OW-1:0], size_reg[LEN_W-1:0]};
                    mv_next = used_reg;
                    state_next = S_SHR;
                    total_next = total_reg + size_reg[LEN_W-1:0];
                end
            end
            S_SHR:
            begin
                // move entry mv-1 to mv, down to the insert point
                if (mv_reg <= (w1v_reg ? w1a_reg : w0a_reg))
                begin
                    used_next = used_reg + CW'(1);
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_SHRW;
                end
            end
            S_SHRW:
            begin
                mv_next = mv_reg - CW'(1);
                state_next = S_SHR;
            end
            S_SHL:
            begin
                // move entry mv+1 to mv up to the end
                if (mv_reg >= used_m1)
                begin
                    used_next = used_m1;
                    state_next = (mode_reg == MODE_ALLOC) ? S_DONE : S_WRITE;
                end
                else
                begin
                    state_next = S_SHLW;
                end
            end
            S_SHLW:
            begin
                mv_next = mv_reg + CW'(1);
                state_next = S_SHL;
            end
            S_WRITE:
            begin
                if (w1v_reg && !wph_reg)
                begin
                    wph_next = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovld_reg || rsp.ready)
                begin
                    ovld_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = idx_reg[IW-1:0];
        ram_wdata = w0_reg;
        case (state_reg)
            S_RD:    ram_addr = idx_reg[IW-1:0];
            S_PRED:  ram_addr = IW'(idx_reg - CW'(1));
            S_PWAIT: ram_addr = IW'(idx_reg - CW'(1));
            S_SHR:   ram_addr = IW'(mv_reg - CW'(1));
            S_SHRW:
            begin
                ram_we = 1'b1;
                ram_addr = mv_reg[IW-1:0];
                ram_wdata = ram_rdata;
            end
            S_SHL:   ram_addr = IW'(mv_reg + CW'(1));
            S_SHLW:
            begin
                ram_we = 1'b1;
                ram_addr = mv_reg[IW-1:0];
                ram_wdata = ram_rdata;
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                if (w1v_reg && wph_reg)
                begin
                    ram_addr = w1a_reg[IW-1:0];
                    ram_wdata = w1_reg;
                end
                else
                begin
                    ram_addr = w0a_reg[IW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE) && !ovld_reg;
    assign rsp.valid = ovld_reg;
    always_comb
    begin
        rsp.data = '0;
        rsp.data.status = status_t'(ost_reg);
        rsp.data.grant_offset = ogo_reg;
        rsp.data.grant_bytes = ogb_reg;
        rsp.data.free_bytes = total_reg;
        rsp.data.extent_count = 7'(used_reg);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_EXTENTS)) else $error("extent count over table size");
    a_busy_noready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready) else $error("ready while busy");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
`endif

endmodule
`default_nettype wire
